@@ rtl/core/spc_pkg.sv @@
`timescale 1ns / 1ps

package spc_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    // hit, first sign, first |v.d|, second sign, second |v.d|, |d|^2, d, v1, v2
    function automatic int entry_width(input int w);
        return 15 * w + 3;
    endfunction

endpackage

@@ rtl/core/sphere_pair_collision_response_core.sv @@
`timescale 1ns / 1ps

// Sphere pair collision response. Takes one pair per clock while in_stall is low and returns
// one result per pair, in order. A pair collides when |D|^2 < R^2, D is nonzero and
// (V1-V2).D < 0; each velocity then has its component along D reversed, as
// V - 2*D*(V.D)/|D|^2, rounded to nearest and saturated, and is otherwise passed through
// with hit low. The quotient pipeline resolves one bit per stage over DATA_WIDTH+3 stages
// for six lanes at once. A four-entry queue sits between the classifying front and the
// reflection back, so a stall on the output holds the input only once the queue is full.
module sphere_pair_collision_response_core #(
    parameter int DATA_WIDTH = spc_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] offset_x,
    input  logic signed [DATA_WIDTH-1:0] offset_y,
    input  logic signed [DATA_WIDTH-1:0] offset_z,
    input  logic signed [DATA_WIDTH-1:0] first_velocity_x,
    input  logic signed [DATA_WIDTH-1:0] first_velocity_y,
    input  logic signed [DATA_WIDTH-1:0] first_velocity_z,
    input  logic signed [DATA_WIDTH-1:0] second_velocity_x,
    input  logic signed [DATA_WIDTH-1:0] second_velocity_y,
    input  logic signed [DATA_WIDTH-1:0] second_velocity_z,
    input  logic        [DATA_WIDTH-1:0] radius_sum,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] new_first_x,
    output logic signed [DATA_WIDTH-1:0] new_first_y,
    output logic signed [DATA_WIDTH-1:0] new_first_z,
    output logic signed [DATA_WIDTH-1:0] new_second_x,
    output logic signed [DATA_WIDTH-1:0] new_second_y,
    output logic signed [DATA_WIDTH-1:0] new_second_z,
    output logic                         hit
);

    localparam int EW = spc_pkg::entry_width(DATA_WIDTH);

    logic          entry_valid;
    logic [EW-1:0] entry;
    logic          full;
    logic          push;
    logic          pop;
    logic          empty;
    logic [EW-1:0] head;

    assign push = entry_valid && !full;

    spc_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .offset_x          (offset_x),
        .offset_y          (offset_y),
        .offset_z          (offset_z),
        .first_velocity_x  (first_velocity_x),
        .first_velocity_y  (first_velocity_y),
        .first_velocity_z  (first_velocity_z),
        .second_velocity_x (second_velocity_x),
        .second_velocity_y (second_velocity_y),
        .second_velocity_z (second_velocity_z),
        .radius_sum        (radius_sum),
        .entry_valid       (entry_valid),
        .entry             (entry),
        .entry_full        (full)
    );

    spc_queue #(
        .WIDTH (EW),
        .DEPTH (spc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    spc_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_first_x  (new_first_x),
        .new_first_y  (new_first_y),
        .new_first_z  (new_first_z),
        .new_second_x (new_second_x),
        .new_second_y (new_second_y),
        .new_second_z (new_second_z),
        .hit          (hit)
    );

endmodule

@@ rtl/core/spc_front.sv @@
`timescale 1ns / 1ps

module spc_front #(
    parameter int DATA_WIDTH = spc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic signed [DATA_WIDTH-1:0]                 offset_x,
    input  logic signed [DATA_WIDTH-1:0]                 offset_y,
    input  logic signed [DATA_WIDTH-1:0]                 offset_z,
    input  logic signed [DATA_WIDTH-1:0]                 first_velocity_x,
    input  logic signed [DATA_WIDTH-1:0]                 first_velocity_y,
    input  logic signed [DATA_WIDTH-1:0]                 first_velocity_z,
    input  logic signed [DATA_WIDTH-1:0]                 second_velocity_x,
    input  logic signed [DATA_WIDTH-1:0]                 second_velocity_y,
    input  logic signed [DATA_WIDTH-1:0]                 second_velocity_z,
    input  logic        [DATA_WIDTH-1:0]                 radius_sum,
    output logic                                         entry_valid,
    output logic [spc_pkg::entry_width(DATA_WIDTH)-1:0]  entry,
    input  logic                                         entry_full
);

    localparam int W  = DATA_WIDTH;
    localparam int EW = spc_pkg::entry_width(DATA_WIDTH);

    logic signed [W-1:0] d_in  [3];
    logic signed [W-1:0] v1_in [3];
    logic signed [W-1:0] v2_in [3];

    logic                  advance;
    logic                  valid_s1_reg;
    logic                  valid_s2_reg;

    logic signed [W-1:0]   d_s1_reg   [3];
    logic signed [W-1:0]   v1_s1_reg  [3];
    logic signed [W-1:0]   v2_s1_reg  [3];
    logic [2*W-1:0]        dsq_s1_reg [3];
    logic [2*W-1:0]        rsq_s1_reg;
    logic signed [2*W:0]   rel_s1_reg [3];
    logic signed [2*W-1:0] p1_s1_reg  [3];
    logic signed [2*W-1:0] p2_s1_reg  [3];

    logic signed [2*W-1:0] dsq_next [3];
    logic [2*W-1:0]        rsq_next;
    logic signed [2*W:0]   rel_next [3];
    logic signed [2*W-1:0] p1_next  [3];
    logic signed [2*W-1:0] p2_next  [3];
    logic signed [W:0]     diff     [3];

    logic [2*W-1:0]        dist2;
    logic signed [2*W+2:0] dot;
    logic signed [2*W+1:0] t1;
    logic signed [2*W+1:0] t2;
    logic signed [2*W+1:0] abs1;
    logic signed [2*W+1:0] abs2;
    logic                  hit;
    logic [EW-1:0]         entry_next;
    logic [EW-1:0]         entry_reg;

    assign d_in[0]  = offset_x;
    assign d_in[1]  = offset_y;
    assign d_in[2]  = offset_z;
    assign v1_in[0] = first_velocity_x;
    assign v1_in[1] = first_velocity_y;
    assign v1_in[2] = first_velocity_z;
    assign v2_in[0] = second_velocity_x;
    assign v2_in[1] = second_velocity_y;
    assign v2_in[2] = second_velocity_z;

    assign advance     = !valid_s2_reg || !entry_full;
    assign in_stall    = !advance;
    assign entry_valid = valid_s2_reg;
    assign entry       = entry_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]     = {v1_in[i][W-1], v1_in[i]} - {v2_in[i][W-1], v2_in[i]};
            dsq_next[i] = d_in[i] * d_in[i];
            rel_next[i] = diff[i] * d_in[i];
            p1_next[i]  = v1_in[i] * d_in[i];
            p2_next[i]  = v2_in[i] * d_in[i];
        end
        rsq_next = radius_sum * radius_sum;
    end

    always_comb
    begin
        dist2 = dsq_s1_reg[0] + dsq_s1_reg[1] + dsq_s1_reg[2];
        dot   = (2*W+3)'(rel_s1_reg[0]) + (2*W+3)'(rel_s1_reg[1])
              + (2*W+3)'(rel_s1_reg[2]);
        t1    = (2*W+2)'(p1_s1_reg[0]) + (2*W+2)'(p1_s1_reg[1])
              + (2*W+2)'(p1_s1_reg[2]);
        t2    = (2*W+2)'(p2_s1_reg[0]) + (2*W+2)'(p2_s1_reg[1])
              + (2*W+2)'(p2_s1_reg[2]);
        abs1  = t1[2*W+1] ? -t1 : t1;
        abs2  = t2[2*W+1] ? -t2 : t2;
        // touching exactly or coincident centres is no hit
        hit   = (dist2 < rsq_s1_reg) && dot[2*W+2] && (dist2 != '0);
        entry_next = {hit, t1[2*W+1], abs1[2*W-1:0], t2[2*W+1], abs2[2*W-1:0], dist2,
                      d_s1_reg[0], d_s1_reg[1], d_s1_reg[2],
                      v1_s1_reg[0], v1_s1_reg[1], v1_s1_reg[2],
                      v2_s1_reg[0], v2_s1_reg[1], v2_s1_reg[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_s1_reg <= in_valid;
            valid_s2_reg <= valid_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_s1_reg[i]   <= d_in[i];
                v1_s1_reg[i]  <= v1_in[i];
                v2_s1_reg[i]  <= v2_in[i];
                dsq_s1_reg[i] <= dsq_next[i];
                rel_s1_reg[i] <= rel_next[i];
                p1_s1_reg[i]  <= p1_next[i];
                p2_s1_reg[i]  <= p2_next[i];
            end
            rsq_s1_reg <= rsq_next;
            entry_reg  <= entry_next;
        end
    end

endmodule

@@ rtl/core/spc_queue.sv @@
`timescale 1ns / 1ps

module spc_queue #(
    parameter int WIDTH = spc_pkg::entry_width(spc_pkg::DATA_WIDTH_DEF),
    parameter int DEPTH = spc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("transfer into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a transfer");

endmodule

@@ rtl/core/spc_back.sv @@
`timescale 1ns / 1ps

module spc_back #(
    parameter int DATA_WIDTH = spc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic [spc_pkg::entry_width(DATA_WIDTH)-1:0]  head,
    input  logic                                         empty,
    output logic                                         pop,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [DATA_WIDTH-1:0]                 new_first_x,
    output logic signed [DATA_WIDTH-1:0]                 new_first_y,
    output logic signed [DATA_WIDTH-1:0]                 new_first_z,
    output logic signed [DATA_WIDTH-1:0]                 new_second_x,
    output logic signed [DATA_WIDTH-1:0]                 new_second_y,
    output logic signed [DATA_WIDTH-1:0]                 new_second_z,
    output logic                                         hit
);

    localparam int W  = DATA_WIDTH;
    localparam int Q  = W + 3;        // quotient bits, |corr| < 2^(W+2)
    localparam int RW = 3 * W + 3;    // remainder and shifted divisor
    localparam int SW = Q + 2;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic                e_hit;
    logic                e_t1neg;
    logic                e_t2neg;
    logic [2*W-1:0]      e_at1;
    logic [2*W-1:0]      e_at2;
    logic [2*W-1:0]      e_dist2;
    logic signed [W-1:0] e_d [3];
    logic signed [W-1:0] e_v [6];

    logic                advance;

    // lane products
    logic signed [W-1:0] lane_d    [6];
    logic [W-1:0]        lane_dmag [6];
    logic [2*W-1:0]      lane_at   [6];
    logic                lane_tneg [6];
    logic [2*W-1:0]      plo_next  [6];
    logic [2*W-1:0]      phi_next  [6];
    logic                neg_next  [6];

    logic                valid_b1_reg;
    logic                hit_b1_reg;
    logic [2*W-1:0]      dist2_b1_reg;
    logic [2*W-1:0]      plo_b1_reg [6];
    logic [2*W-1:0]      phi_b1_reg [6];
    logic signed [W-1:0] v_b1_reg   [6];
    logic                neg_b1_reg [6];

    // quotient pipeline, one bit per stage
    logic                valid_st_reg [Q+1];
    logic                hit_st_reg   [Q+1];
    logic [2*W-1:0]      dist2_st_reg [Q+1];
    logic [RW-1:0]       rem_st_reg   [Q+1][6];
    logic [Q-1:0]        quo_st_reg   [Q+1][6];
    logic signed [W-1:0] v_st_reg     [Q+1][6];
    logic                neg_st_reg   [Q+1][6];

    logic [RW-1:0]       rem_next [Q+1][6];
    logic [Q-1:0]        quo_next [Q+1][6];
    logic [RW-1:0]       num      [6];
    logic [RW-1:0]       dsh      [Q+1];

    logic signed [SW-1:0] corr [6];
    logic signed [SW-1:0] sum  [6];
    logic signed [W-1:0]  res_next [6];
    logic signed [W-1:0]  res_reg  [6];
    logic                 out_valid_reg;
    logic                 hit_reg;

    assign {e_hit, e_t1neg, e_at1, e_t2neg, e_at2, e_dist2, e_d[0], e_d[1], e_d[2],
            e_v[0], e_v[1], e_v[2], e_v[3], e_v[4], e_v[5]} = head;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !empty;

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            lane_d[j]    = e_d[(j < 3) ? j : j - 3];
            lane_at[j]   = (j < 3) ? e_at1 : e_at2;
            lane_tneg[j] = (j < 3) ? e_t1neg : e_t2neg;
            lane_dmag[j] = lane_d[j][W-1] ? W'(-lane_d[j]) : W'(lane_d[j]);
            plo_next[j]  = lane_at[j][W-1:0] * lane_dmag[j];
            phi_next[j]  = lane_at[j][2*W-1:W] * lane_dmag[j];
            neg_next[j]  = lane_tneg[j] ^ lane_d[j][W-1];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            // 2*|v.d|*|d_i| + |d|^2/2 for round to nearest
            num[j] = ((RW'(phi_b1_reg[j]) << W) + RW'(plo_b1_reg[j])) << 1;
            rem_next[0][j] = num[j] + RW'(dist2_b1_reg >> 1);
            quo_next[0][j] = '0;
        end
        dsh[0] = '0;
        for (int s = 1; s <= Q; s++)
        begin
            dsh[s] = RW'(dist2_st_reg[s-1]) << (Q - s);
            for (int j = 0; j < 6; j++)
            begin
                rem_next[s][j] = rem_st_reg[s-1][j];
                quo_next[s][j] = quo_st_reg[s-1][j];
                if (rem_st_reg[s-1][j] >= dsh[s])
                begin
                    rem_next[s][j]       = rem_st_reg[s-1][j] - dsh[s];
                    quo_next[s][j][Q-s]  = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            corr[j] = SW'({1'b0, quo_st_reg[Q][j]});
            sum[j]  = SW'(v_st_reg[Q][j]) - (neg_st_reg[Q][j] ? -corr[j] : corr[j]);
            if (!hit_st_reg[Q])
                res_next[j] = v_st_reg[Q][j];
            else if (sum[j] > SAT_HI)
                res_next[j] = SAT_HI[W-1:0];
            else if (sum[j] < SAT_LO)
                res_next[j] = SAT_LO[W-1:0];
            else
                res_next[j] = sum[j][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b1_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s <= Q; s++)
                valid_st_reg[s] <= 1'b0;
        end
        else if (advance)
        begin
            valid_b1_reg    <= !empty;
            valid_st_reg[0] <= valid_b1_reg;
            for (int s = 1; s <= Q; s++)
                valid_st_reg[s] <= valid_st_reg[s-1];
            out_valid_reg   <= valid_st_reg[Q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_b1_reg   <= e_hit;
            dist2_b1_reg <= e_dist2;
            for (int j = 0; j < 6; j++)
            begin
                plo_b1_reg[j] <= plo_next[j];
                phi_b1_reg[j] <= phi_next[j];
                v_b1_reg[j]   <= e_v[j];
                neg_b1_reg[j] <= neg_next[j];
            end
            hit_st_reg[0]   <= hit_b1_reg;
            dist2_st_reg[0] <= dist2_b1_reg;
            for (int j = 0; j < 6; j++)
            begin
                v_st_reg[0][j]   <= v_b1_reg[j];
                neg_st_reg[0][j] <= neg_b1_reg[j];
            end
            for (int s = 1; s <= Q; s++)
            begin
                hit_st_reg[s]   <= hit_st_reg[s-1];
                dist2_st_reg[s] <= dist2_st_reg[s-1];
                for (int j = 0; j < 6; j++)
                begin
                    v_st_reg[s][j]   <= v_st_reg[s-1][j];
                    neg_st_reg[s][j] <= neg_st_reg[s-1][j];
                end
            end
            for (int s = 0; s <= Q; s++)
            begin
                for (int j = 0; j < 6; j++)
                begin
                    rem_st_reg[s][j] <= rem_next[s][j];
                    quo_st_reg[s][j] <= quo_next[s][j];
                end
            end
            for (int j = 0; j < 6; j++)
                res_reg[j] <= res_next[j];
            hit_reg <= hit_st_reg[Q];
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_first_x  = res_reg[0];
    assign new_first_y  = res_reg[1];
    assign new_first_z  = res_reg[2];
    assign new_second_x = res_reg[3];
    assign new_second_y = res_reg[4];
    assign new_second_z = res_reg[5];
    assign hit          = hit_reg;

endmodule
